### rtl/core/ffca_pkg.sv
// Shared types, constants and sequencer codes of the first-fit allocator.
package ffca_pkg;

  localparam int unsigned MaxRegionBytesDef  = 65536;
  localparam int unsigned PageBytesDef       = 4096;
  localparam int unsigned MaxFreeSegmentsDef = 64;

  localparam int unsigned Grain       = 8;
  localparam int unsigned OffsetLimit = 65536;

  // Free-table entry: segment start and length
  typedef struct packed {
    logic [15:0] start;
    logic [16:0] len;
  } seg_t;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusNoFit  = 2'd1;
  localparam logic [1:0] StatusFull   = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StAChk  = 3'd1;
  localparam logic [2:0] StRem   = 3'd2;
  localparam logic [2:0] StFLen  = 3'd3;
  localparam logic [2:0] StFScan = 3'd4;
  localparam logic [2:0] StIns   = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

endpackage

### rtl/core/ffca_ram.sv
// Generic simple dual-port RAM with registered read.
module ffca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/first_fit_coalescing_allocator_core.sv
// Top level: first-fit allocator sequencer with free table and size store.
//
// Requests arrive on the in channel (valid/ready): operation 0 allocates
// request_bytes, operation 1 frees the block at release_offset. Each request
// gives exactly one result on the out channel (valid/ready): status and
// payload_offset.
// One request is worked on at a time. The sequencer walks the free table one
// entry per cycle through the table RAM's single read port and shifts entries
// one per cycle on removal or insertion. The block is ready for the next
// request as soon as the result is registered.
// A finished result waits in the output register; the block takes the next
// request meanwhile and holds its own finish until the receiver takes the
// waiting one.
// After reset, and after each cfg_we_i write of the region size, the block writes
// the single free segment covering the page-rounded region before accepting
// requests. PAGE_BYTES must be a power of two.
module first_fit_coalescing_allocator_core
  import ffca_pkg::*;
#(
  parameter int unsigned MAX_REGION_BYTES  = MaxRegionBytesDef,
  parameter int unsigned PAGE_BYTES        = PageBytesDef,
  parameter int unsigned MAX_FREE_SEGMENTS = MaxFreeSegmentsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [16:0] request_bytes_i,
  input  logic [15:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] payload_offset_o
);

  localparam int unsigned RegionLimit =
      (MAX_REGION_BYTES < OffsetLimit) ? MAX_REGION_BYTES : OffsetLimit;
  localparam int unsigned StoreDepth = RegionLimit / Grain;
  localparam int unsigned StoreAW    = $clog2(StoreDepth);
  localparam int unsigned AddrW      = $clog2(MAX_FREE_SEGMENTS);
  localparam int unsigned IdxW       = $clog2(MAX_FREE_SEGMENTS + 1);
  localparam logic [31:0] PageMask   = 32'(PAGE_BYTES - 1);

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d, k_q, k_d, cnt_q, cnt_d;
  logic [17:0]     need_q, need_d, blen_q, blen_d;
  logic [16:0]     size_q, size_d;
  logic [15:0]     hdr_q, hdr_d;
  seg_t            prev_q, prev_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [15:0]     res_off_q, res_off_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [15:0]     out_off_q, out_off_d;
  logic [16:0]     region_q;
  logic            init_q, init_d;

  logic             t_we;
  logic [AddrW-1:0] t_waddr, t_raddr;
  seg_t             t_wdata, t_rdata;
  logic             s_we;
  logic [StoreAW-1:0] s_waddr, s_raddr;
  logic [16:0]      s_wdata, s_rdata;

  logic [31:0]     round_sum, round_bytes;
  logic [16:0]     region_bytes;
  logic [IdxW-1:0] idx_p1, idx_p2, idx_m1, k_m1, k_m2, cnt_m1;
  logic [17:0]     req_size, fl_hdr_sum, fp_end;
  logic [15:0]     fr_hdr;
  logic [12:0]     fr_gran, st_gran;
  logic            in_tab, fit, join_prev, join_next;

  ffca_ram #(.Width($bits(seg_t)), .Depth(MAX_FREE_SEGMENTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  ffca_ram #(.Width(17), .Depth(StoreDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Round region up to whole pages, then clamp
  assign round_sum    = 32'(region_q) + PageMask;
  assign round_bytes  = round_sum & ~PageMask;
  assign region_bytes = (round_bytes > 32'(RegionLimit)) ? 17'(RegionLimit)
                                                         : round_bytes[16:0];

  assign idx_p1 = idx_q + IdxW'(1);
  assign idx_p2 = idx_q + IdxW'(2);
  assign idx_m1 = idx_q - IdxW'(1);
  assign k_m1   = k_q - IdxW'(1);
  assign k_m2   = k_q - IdxW'(2);
  assign cnt_m1 = cnt_q - IdxW'(1);

  assign req_size   = ({1'b0, request_bytes_i} + 18'd7) & ~18'd7;
  assign fr_hdr     = release_offset_i - 16'd8;
  assign fr_gran    = fr_hdr[15:3];
  assign st_gran    = t_rdata.start[15:3];
  assign in_tab     = idx_q < cnt_q;
  assign fit        = ({1'b0, t_rdata.len} >= need_q) && (t_rdata.start < 16'd65528);
  assign fp_end     = {2'b0, prev_q.start} + {1'b0, prev_q.len};
  assign fl_hdr_sum = {2'b0, hdr_q} + blen_q;
  assign join_prev  = (idx_q != '0) && (fp_end == {2'b0, hdr_q});
  assign join_next  = in_tab && (fl_hdr_sum == {2'b0, t_rdata.start});

  assign in_ready_o = (state_q == StIdle) && !init_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    need_d       = need_q;
    blen_d       = blen_q;
    size_d       = size_q;
    hdr_d        = hdr_q;
    prev_d       = prev_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    init_d       = init_q;
    t_we         = 1'b0;
    t_waddr      = idx_q[AddrW-1:0];
    t_wdata      = t_rdata;
    t_raddr      = idx_p1[AddrW-1:0];
    s_we         = 1'b0;
    s_waddr      = st_gran[StoreAW-1:0];
    s_wdata      = size_q;
    s_raddr      = fr_gran[StoreAW-1:0];

    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_off_d    = out_off_q;

    unique case (state_q)
      StIdle: begin
        if (init_q) begin
          t_we    = 1'b1;
          t_waddr = '0;
          t_wdata = '{start: 16'd0, len: region_bytes};
          cnt_d   = (region_bytes != '0) ? IdxW'(1) : '0;
          init_d  = 1'b0;
        end else if (in_valid_i) begin
          res_status_d = StatusOk;
          res_off_d    = '0;
          idx_d        = '0;
          t_raddr      = '0;
          if (operation_i == OpAlloc) begin
            size_d  = req_size[16:0];
            need_d  = req_size + 18'd8;
            state_d = StAChk;
          end else if (release_offset_i < 16'd8 || release_offset_i[2:0] != 3'd0
                       || 32'(fr_gran) >= 32'(StoreDepth)) begin
            // drop null and malformed frees
            state_d = StFin;
          end else begin
            hdr_d   = fr_hdr;
            state_d = StFLen;
          end
        end
      end
      StAChk: begin
        if (!in_tab) begin
          res_status_d = StatusNoFit;
          state_d      = StFin;
        end else if (fit) begin
          s_we      = 32'(st_gran) < 32'(StoreDepth);
          res_off_d = t_rdata.start + 16'd8;
          if ({1'b0, t_rdata.len} == need_q) begin
            state_d = StRem;
          end else begin
            t_we    = 1'b1;
            t_wdata = '{start: t_rdata.start + need_q[15:0],
                        len:   t_rdata.len - need_q[16:0]};
            state_d = StFin;
          end
        end else begin
          idx_d = idx_p1;
        end
      end
      StRem: begin
        // read data holds entry idx+1: move it down one place
        t_raddr = idx_p2[AddrW-1:0];
        if (idx_p1 < cnt_q) begin
          t_we  = 1'b1;
          idx_d = idx_p1;
        end else begin
          cnt_d   = cnt_q - IdxW'(1);
          state_d = StFin;
        end
      end
      StFLen: begin
        blen_d  = {1'b0, s_rdata} + 18'd8;
        t_raddr = '0;
        state_d = StFScan;
      end
      StFScan: begin
        if (in_tab && t_rdata.start <= hdr_q) begin
          prev_d = t_rdata;
          idx_d  = idx_p1;
        end else if (join_prev && join_next) begin
          t_we    = 1'b1;
          t_waddr = idx_m1[AddrW-1:0];
          t_wdata = '{start: prev_q.start,
                      len:   prev_q.len + blen_q[16:0] + t_rdata.len};
          state_d = StRem;
        end else if (join_prev) begin
          t_we    = 1'b1;
          t_waddr = idx_m1[AddrW-1:0];
          t_wdata = '{start: prev_q.start, len: prev_q.len + blen_q[16:0]};
          state_d = StFin;
        end else if (join_next) begin
          t_we    = 1'b1;
          t_wdata = '{start: hdr_q, len: t_rdata.len + blen_q[16:0]};
          state_d = StFin;
        end else if (32'(cnt_q) >= 32'(MAX_FREE_SEGMENTS)) begin
          res_status_d = StatusFull;
          state_d      = StFin;
        end else begin
          k_d     = cnt_q;
          t_raddr = cnt_m1[AddrW-1:0];
          state_d = StIns;
        end
      end
      StIns: begin
        // read data holds entry k-1: move it up one place
        t_raddr = k_m2[AddrW-1:0];
        if (k_q > idx_q) begin
          t_we    = 1'b1;
          t_waddr = k_q[AddrW-1:0];
          k_d     = k_m1;
        end else begin
          t_we    = 1'b1;
          t_wdata = '{start: hdr_q, len: blen_q[16:0]};
          cnt_d   = cnt_q + IdxW'(1);
          state_d = StFin;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_off_d    = res_off_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      region_q    <= 17'h10000;
      init_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        region_q <= cfg_wdata_i;
        init_q   <= 1'b1;
      end else begin
        init_q   <= init_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    k_q          <= k_d;
    need_q       <= need_d;
    blen_q       <= blen_d;
    size_q       <= size_d;
    hdr_q        <= hdr_d;
    prev_q       <= prev_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    out_status_q <= out_status_d;
    out_off_q    <= out_off_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign payload_offset_o = out_off_q;

endmodule
